[rtl/epsilon_closure_reachability_defines.svh]
// assertion macros shared by the checker
`ifndef EPSILON_CLOSURE_REACHABILITY_DEFINES_SVH
`define EPSILON_CLOSURE_REACHABILITY_DEFINES_SVH

// property checked outside reset
`define ECR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property that also covers the reset cycles
`define ECR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[rtl/ecr_pkg.sv]
package ecr_pkg;

  // fixed field widths and queue depth
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CFG_W   = 6;
  localparam int unsigned SET_W   = 32;
  localparam int unsigned Q_DEPTH = 2;

  // command codes on the input channel
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADD,
    OP_QUERY,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             err;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
  } job_t;

  typedef struct packed {
    logic [SET_W-1:0] closure;
    logic             err;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ADD,
    BK_QUERY
  } bk_state_t;

endpackage

[rtl/epsilon_closure_reachability.sv]
// channel   dir   handshake              payload
// in_       in    in_tvalid/in_tready    tuser command, tdata from_state, to_state
// out_      out   out_tvalid/out_tready  tdata closure_set, tuser error
// cfg_      in    cfg_wr_en              cfg_wr_data num_states
//
// into an idle back end, clear, error and unknown commands are answered straight
// from the idle state and add is answered after a row read, then a write back
// a query reads one edge row per reached state, a row is merged into the reach
// register before the next state of a chain can be read
// reset clears all edges at once through per-row valid bits and sets num_states to 32
// a 2-entry queue decouples intake from the back end, the output register holds
// a result while out_tready is low
module epsilon_closure_reachability
  import ecr_pkg::*;
#(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,   // from_state, to_state, zero pad
  input  logic [1:0]       in_tuser,   // command
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [SET_W-1:0] out_tdata,  // closure_set
  output logic [0:0]       out_tuser,  // error
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);

  logic [CFG_W-1:0] num_states_r;
  logic [CNT_W-1:0] act_cnt;
  job_t             front_job;
  job_t             q_job;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic             res_valid;
  result_t          res;

  // state count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r <= 6'd32;
    end else if (cfg_wr_en) begin
      num_states_r <= cfg_wr_data;
    end
  end

  // active count is num_states capped at the matrix size
  assign act_cnt = (int'(num_states_r) > int'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                           : CNT_W'(num_states_r);

  assign in_tready = !q_full;

  ecr_front #(
    .CNT_W (CNT_W)
  ) u_front (
    .in_cmd  (in_tuser),
    .in_src  (in_tdata[IDX_W-1:0]),
    .in_dst  (in_tdata[2*IDX_W-1:IDX_W]),
    .act_cnt (act_cnt),
    .job     (front_job)
  );

  ecr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_tvalid && in_tready),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  ecr_back #(
    .MAX_NODES (MAX_NODES),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .act_cnt   (act_cnt),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = res.closure;
  assign out_tuser  = res.err;

endmodule

[rtl/ecr_front.sv]
module ecr_front
  import ecr_pkg::*;
#(
  parameter int unsigned CNT_W = 6
) (
  input  logic [1:0]       in_cmd,
  input  logic [IDX_W-1:0] in_src,
  input  logic [IDX_W-1:0] in_dst,
  input  logic [CNT_W-1:0] act_cnt,
  output job_t             job
);

  logic src_ok;
  logic dst_ok;

  // range checks against the active state count
  assign src_ok = int'(in_src) < int'(act_cnt);
  assign dst_ok = int'(in_dst) < int'(act_cnt);

  // classify the command, out of range indexes become error results
  always_comb begin
    job.src = in_src;
    job.dst = in_dst;
    job.err = 1'b0;
    job.op  = OP_NONE;
    case (in_cmd)
      CMD_ADD: begin
        if (src_ok && dst_ok) job.op = OP_ADD;
        else job.err = 1'b1;
      end
      CMD_QUERY: begin
        if (src_ok) job.op = OP_QUERY;
        else job.err = 1'b1;
      end
      CMD_CLEAR: begin
        job.op = OP_CLEAR;
      end
      default: begin
        job.op = OP_NONE;
      end
    endcase
  end

endmodule

[rtl/ecr_queue.sv]
module ecr_queue
  import ecr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  job_t             slot_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full    = (cnt_r == CNT_W'(Q_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

endmodule

[rtl/ecr_back.sv]
module ecr_back
  import ecr_pkg::*;
#(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned CNT_W     = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] act_cnt,
  input  logic             q_empty,
  input  job_t             q_job,
  output logic             q_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam logic [MAX_NODES-1:0] ONE = {{(MAX_NODES - 1){1'b0}}, 1'b1};

  // edge matrix, one row per source state
  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_vld_r;
  logic [MAX_NODES-1:0] rd_data_r;
  logic                 rd_hit_r;

  logic                 rd_en;
  logic [NODE_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [NODE_W-1:0]    wr_addr;
  logic [MAX_NODES-1:0] wr_data;
  logic                 clr_all;

  bk_state_t            state_r;
  bk_state_t            state_nxt;
  logic [MAX_NODES-1:0] reach_r;
  logic [MAX_NODES-1:0] reach_nxt;
  logic [MAX_NODES-1:0] done_r;
  logic [MAX_NODES-1:0] done_nxt;
  logic                 rd_pend_r;
  logic                 rd_pend_nxt;
  logic [NODE_W-1:0]    src_r;
  logic [NODE_W-1:0]    src_nxt;
  logic [NODE_W-1:0]    dst_r;
  logic [NODE_W-1:0]    dst_nxt;
  result_t              res_r;
  result_t              res_nxt;
  logic                 res_vld_r;
  logic                 res_vld_nxt;

  logic [MAX_NODES-1:0] keep;
  logic [MAX_NODES-1:0] row;
  logic [MAX_NODES-1:0] pend;
  logic [NODE_W-1:0]    pick_idx;
  logic                 slot_free;
  logic [63:0]          reach_wide;

  assign res_valid  = res_vld_r;
  assign res        = res_r;
  assign slot_free  = !res_vld_r || res_ready;
  assign row        = rd_hit_r ? rd_data_r : '0;
  assign pend       = reach_r & ~done_r;
  assign reach_wide = 64'(reach_r);

  // mask of states below the active count
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      keep[i] = (i < int'(act_cnt));
    end
  end

  // lowest reached state whose row is not yet fetched
  always_comb begin
    pick_idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (pend[i]) pick_idx = NODE_W'(i);
    end
  end

  // sequencer: next state, memory access and result
  always_comb begin
    state_nxt   = state_r;
    reach_nxt   = reach_r;
    done_nxt    = done_r;
    rd_pend_nxt = 1'b0;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r && !res_ready;
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = src_r;
    wr_en       = 1'b0;
    wr_addr     = src_r;
    wr_data     = row | (ONE << dst_r);
    clr_all     = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty && slot_free) begin
          q_pop   = 1'b1;
          src_nxt = NODE_W'(q_job.src);
          dst_nxt = NODE_W'(q_job.dst);
          case (q_job.op)
            OP_ADD: begin
              rd_en     = 1'b1;
              rd_addr   = NODE_W'(q_job.src);
              state_nxt = BK_ADD;
            end
            OP_QUERY: begin
              reach_nxt = ONE << NODE_W'(q_job.src);
              done_nxt  = '0;
              state_nxt = BK_QUERY;
            end
            OP_CLEAR: begin
              clr_all         = 1'b1;
              res_vld_nxt     = 1'b1;
              res_nxt.closure = '0;
              res_nxt.err     = 1'b0;
            end
            default: begin
              res_vld_nxt     = 1'b1;
              res_nxt.closure = '0;
              res_nxt.err     = q_job.err;
            end
          endcase
        end
      end
      BK_ADD: begin
        // row read issued from idle, write it back with the new edge
        if (slot_free) begin
          wr_en           = 1'b1;
          res_vld_nxt     = 1'b1;
          res_nxt.closure = '0;
          res_nxt.err     = 1'b0;
          state_nxt       = BK_IDLE;
        end
      end
      BK_QUERY: begin
        // merge the row that arrived, fetch the next pending one
        if (rd_pend_r) reach_nxt = reach_r | (row & keep);
        if (pend != '0) begin
          rd_en       = 1'b1;
          rd_addr     = pick_idx;
          done_nxt    = done_r | (ONE << pick_idx);
          rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r && slot_free) begin
          res_vld_nxt     = 1'b1;
          res_nxt.closure = reach_wide[SET_W-1:0];
          res_nxt.err     = 1'b0;
          state_nxt       = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      rd_pend_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    reach_r <= reach_nxt;
    done_r  <= done_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    res_r   <= res_nxt;
  end

  // row valid bits, cleared together by reset or the clear command
  always_ff @(posedge clk) begin
    if (!rst_n || clr_all) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  // edge memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_hit_r  <= row_vld_r[rd_addr];
    end
  end

endmodule

[rtl/ecr_checker.sv]
`include "epsilon_closure_reachability_defines.svh"

module ecr_checker
  import ecr_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [SET_W-1:0] out_tdata,
  input logic [0:0]       out_tuser
);

  // block comes out of reset empty and ready
  `ECR_ASSERT_RST(a_reset_empty, !rst_n |=> (!out_tvalid && in_tready), "not empty after reset")

  // a stalled result beat holds
  `ECR_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "result changed under stall")

  // an error beat never carries a closure
  `ECR_ASSERT(a_err_empty, (out_tvalid && out_tuser[0]) |-> (out_tdata == '0), "error beat with closure bits")

endmodule

bind epsilon_closure_reachability ecr_checker u_ecr_checker (.*);
